FILE: hw/rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg: shared types and constants of the linear interpolation resampler
// Register map, sequencer states, divider request/response and reset values.
// ----------------------------------------------------------------------------
package lir_pkg;

  // Run limit default and sample constants
  localparam int LIR_MAX_RUN = 64;
  localparam int LIR_DIV_W   = 16;
  localparam int LIR_DIV_CNT_W = $clog2(LIR_DIV_W);
  localparam int LIR_ADDR_W  = 4;

  localparam logic [14:0] CLAMP_MAG  = 15'd32767;
  localparam logic [15:0] UNITY_GAIN = 16'd4096;

  // Register reset values
  localparam logic [15:0] IN_STEP_RST  = 16'd320;
  localparam logic [15:0] OUT_STEP_RST = 16'd320;
  localparam logic        MONO_RST     = 1'b0;
  localparam logic [15:0] GAIN_RST     = UNITY_GAIN;

  // Register indexes (byte address 4*index)
  typedef enum logic [1:0] {
    REG_IN_STEP  = 2'd0,
    REG_OUT_STEP = 2'd1,
    REG_MONO     = 2'd2,
    REG_GAIN     = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_GAIN,
    ST_EMIT,
    ST_SKIP_START,
    ST_SKIP_WAIT
  } state_t;

  // Divider request and response
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quo;
    logic [15:0] rem;
  } div_rsp_t;

endpackage

FILE: hw/rtl/lir_div.sv
// ----------------------------------------------------------------------------
// lir_div: shared iterative divider
// Restoring division, one quotient bit per cycle. The dividend's upper half
// must be below the divisor, so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module lir_div import lir_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [15:0]              rem_r;
  logic [15:0]              dvd_r;
  logic [15:0]              div_r;
  logic [LIR_DIV_CNT_W-1:0] cnt_r;
  logic                     busy_r;
  logic                     done_r;

  logic [16:0] trial;
  logic        fits;
  logic [15:0] rem_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, dvd_r[15]};
    fits    = trial >= {1'b0, div_r};
    rem_nxt = fits ? 16'(trial - {1'b0, div_r}) : trial[15:0];
  end

  // Control: count steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + LIR_DIV_CNT_W'(1);
      if (cnt_r == LIR_DIV_CNT_W'(LIR_DIV_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: quotient bits enter the low end of the dividend register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[31:16];
      dvd_r <= req.dividend[15:0];
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[14:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = dvd_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: hw/rtl/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler: linear interpolation sample rate converter
// Takes stereo or mono 16-bit frames and emits interpolated, gain-scaled
// frames at the rate set by in_step and out_step.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_left, in_right) enter on in_valid/in_ready; result items
//   (out_left, out_right, out_last) leave on out_valid/out_ready. out_last
//   marks the final result caused by an input item. in_ready is high only
//   while the block is idle; one item is in work at a time.
//   Registers are written over the APB port (in_step 0x0, out_step 0x4,
//   mono 0x8, gain 0xC); any write restarts the stream, and the next item
//   only loads the previous frame.
//   Sequence: with the receiver ready, each result passes the check state,
//   then per channel the multiply states MUL_A and MUL_B, a pass through
//   the shared divider (start, then wait) and the gain state, and then
//   the output register. An exact hit (phase zero) skips the divider. When
//   the run limit cuts a run short, the phase is advanced by one more
//   divider pass.
//   The divider is the pacing unit: every interpolated channel value needs
//   one full pass through it.
//   Reset clears the stream state and loads the register defaults. A
//   stalled receiver holds the result in the output register and the
//   sequencer waits until it is taken.
// ----------------------------------------------------------------------------
module linear_interp_resampler import lir_pkg::*; #(
  parameter int MAX_RUN = LIR_MAX_RUN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    in_left,
  input  logic signed [15:0]    in_right,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    out_left,
  output logic signed [15:0]    out_right,
  output logic                  out_last,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [LIR_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int CNT_W = $clog2(MAX_RUN + 1);

  // Configuration registers
  logic [15:0] in_step_r;
  logic [15:0] out_step_r;
  logic        mono_r;
  logic [15:0] gain_r;

  // Stream state and sequencer registers
  state_t                state_r, state_nxt;
  logic signed [15:0]    prev_left_r, prev_left_nxt;
  logic signed [15:0]    prev_right_r, prev_right_nxt;
  logic signed [15:0]    cur_left_r, cur_left_nxt;
  logic signed [15:0]    cur_right_r, cur_right_nxt;
  logic [17:0]           phase_r, phase_nxt;
  logic                  started_r, started_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ch_r, ch_nxt;
  logic signed [32:0]    prod_r, prod_nxt;
  logic signed [32:0]    num_r, num_nxt;
  logic                  sgn_r, sgn_nxt;
  logic [15:0]           qmag_r, qmag_nxt;
  logic signed [15:0]    res_left_r, res_left_nxt;
  logic signed [15:0]    out_left_r, out_left_nxt;
  logic signed [15:0]    out_right_r, out_right_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Working signals
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic [15:0]        istep;
  logic [15:0]        ostep;
  logic               phase_lt;
  logic [15:0]        diff;
  logic signed [15:0] a_sel;
  logic signed [15:0] b_sel;
  logic [32:0]        num_abs;
  logic [16:0]        a_ext;
  logic [16:0]        a_abs;
  logic [31:0]        gprod;
  logic [19:0]        gsh;
  logic [14:0]        mag;
  logic [15:0]        smag;
  logic signed [15:0] val;
  logic [17:0]        phase_add;
  logic [CNT_W-1:0]   cnt_inc;
  logic               is_last;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // Shared divider
  lir_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_step_r  <= IN_STEP_RST;
      out_step_r <= OUT_STEP_RST;
      mono_r     <= MONO_RST;
      gain_r     <= GAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IN_STEP:  in_step_r  <= pwdata[15:0];
        REG_OUT_STEP: out_step_r <= pwdata[15:0];
        REG_MONO:     mono_r     <= pwdata[0];
        REG_GAIN:     gain_r     <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IN_STEP:  prdata = {16'b0, in_step_r};
      REG_OUT_STEP: prdata = {16'b0, out_step_r};
      REG_MONO:     prdata = {31'b0, mono_r};
      REG_GAIN:     prdata = {16'b0, gain_r};
      default:      prdata = '0;
    endcase
  end

  // Step values, a zero step acts as one
  assign istep = (in_step_r == 16'd0) ? 16'd1 : in_step_r;
  assign ostep = (out_step_r == 16'd0) ? 16'd1 : out_step_r;

  // Phase and channel operand selection
  always_comb begin
    phase_lt  = phase_r < {2'b0, istep};
    diff      = istep - phase_r[15:0];
    a_sel     = ch_r ? (mono_r ? prev_left_r : prev_right_r) : prev_left_r;
    b_sel     = ch_r ? (mono_r ? cur_left_r : cur_right_r) : cur_left_r;
    num_abs   = num_r[32] ? 33'(-num_r) : 33'(num_r);
    a_ext     = {a_sel[15], a_sel};
    a_abs     = a_sel[15] ? 17'(-a_ext) : a_ext;
    phase_add = phase_r + {2'b0, ostep};
    cnt_inc   = cnt_r + CNT_W'(1);
    is_last   = (phase_add >= {2'b0, istep}) || (cnt_inc == CNT_W'(MAX_RUN));
  end

  // Gain and clamp on the quotient or exact-hit magnitude; at unity gain an exact hit passes the sample as is
  always_comb begin
    gprod = {16'b0, qmag_r} * {16'b0, gain_r};
    gsh   = gprod[31:12];
    if (gain_r == UNITY_GAIN) begin
      mag = (qmag_r > {1'b0, CLAMP_MAG}) ? CLAMP_MAG : qmag_r[14:0];
    end else begin
      mag = (gsh > {5'b0, CLAMP_MAG}) ? CLAMP_MAG : gsh[14:0];
    end
    smag = {1'b0, mag};
    if ((gain_r == UNITY_GAIN) && (phase_r == 18'd0)) begin
      val = a_sel;
    end else begin
      val = sgn_r ? $signed(~smag + 16'd1) : $signed(smag);
    end
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt      = state_r;
    prev_left_nxt  = prev_left_r;
    prev_right_nxt = prev_right_r;
    cur_left_nxt   = cur_left_r;
    cur_right_nxt  = cur_right_r;
    phase_nxt      = phase_r;
    started_nxt    = started_r;
    cnt_nxt        = cnt_r;
    ch_nxt         = ch_r;
    prod_nxt       = prod_r;
    num_nxt        = num_r;
    sgn_nxt        = sgn_r;
    qmag_nxt       = qmag_r;
    res_left_nxt   = res_left_r;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r;
    div_req        = '0;

    case (state_r)
      // Take an item; the first one only loads the previous frame
      ST_IDLE: begin
        if (in_valid) begin
          cur_left_nxt  = in_left;
          cur_right_nxt = in_right;
          if (!started_r) begin
            prev_left_nxt  = in_left;
            prev_right_nxt = in_right;
            started_nxt    = 1'b1;
          end else begin
            cnt_nxt   = '0;
            state_nxt = ST_CHECK;
          end
        end
      end
      // Decide: next result, skip past the run limit, or finish the item
      ST_CHECK: begin
        if (phase_lt) begin
          if (cnt_r == CNT_W'(MAX_RUN)) begin
            state_nxt = ST_SKIP_START;
          end else begin
            ch_nxt    = 1'b0;
            state_nxt = ST_MUL_A;
          end
        end else begin
          phase_nxt      = phase_r - {2'b0, istep};
          prev_left_nxt  = cur_left_r;
          prev_right_nxt = cur_right_r;
          state_nxt      = ST_IDLE;
        end
      end
      // prev * (step - p)
      ST_MUL_A: begin
        prod_nxt  = $signed({{17{a_sel[15]}}, a_sel}) * $signed({17'b0, diff});
        state_nxt = ST_MUL_B;
      end
      // add cur * p
      ST_MUL_B: begin
        num_nxt   = prod_r + $signed({{17{b_sel[15]}}, b_sel})
                    * $signed({17'b0, phase_r[15:0]});
        state_nxt = ST_DIV_START;
      end
      // Divide the magnitude by the step, or pass an exact hit
      ST_DIV_START: begin
        if (phase_r == 18'd0) begin
          qmag_nxt  = a_abs[15:0];
          sgn_nxt   = a_sel[15];
          state_nxt = ST_GAIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = num_abs[31:0];
          div_req.divisor  = istep;
          sgn_nxt          = num_r[32];
          state_nxt        = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          qmag_nxt  = div_rsp.quo;
          state_nxt = ST_GAIN;
        end
      end
      // Scale, then either start the right channel or load the output
      ST_GAIN: begin
        if (!ch_r) begin
          res_left_nxt = val;
          ch_nxt       = 1'b1;
          state_nxt    = ST_MUL_A;
        end else begin
          out_left_nxt  = res_left_r;
          out_right_nxt = val;
          out_last_nxt  = is_last;
          out_valid_nxt = 1'b1;
          phase_nxt     = phase_add;
          cnt_nxt       = cnt_inc;
          state_nxt     = ST_EMIT;
        end
      end
      // Hold the result until the receiver takes it
      ST_EMIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_CHECK;
        end
      end
      // Advance the phase past the dropped results: ostep - 1 - ((d - 1) mod ostep)
      ST_SKIP_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = {16'b0, diff - 16'd1};
        div_req.divisor  = ostep;
        state_nxt        = ST_SKIP_WAIT;
      end
      ST_SKIP_WAIT: begin
        if (div_rsp.done) begin
          phase_nxt      = {2'b0, ostep - 16'd1 - div_rsp.rem};
          prev_left_nxt  = cur_left_r;
          prev_right_nxt = cur_right_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Any register write restarts the stream
    if (cfg_wr) begin
      prev_left_nxt  = '0;
      prev_right_nxt = '0;
      phase_nxt      = '0;
      started_nxt    = 1'b0;
    end
  end

  // State register and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      started_r    <= 1'b0;
      phase_r      <= '0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      cnt_r        <= '0;
      ch_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      started_r    <= started_nxt;
      phase_r      <= phase_nxt;
      prev_left_r  <= prev_left_nxt;
      prev_right_r <= prev_right_nxt;
      cnt_r        <= cnt_nxt;
      ch_r         <= ch_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_left_r  <= cur_left_nxt;
    cur_right_r <= cur_right_nxt;
    prod_r      <= prod_nxt;
    num_r       <= num_nxt;
    sgn_r       <= sgn_nxt;
    qmag_r      <= qmag_nxt;
    res_left_r  <= res_left_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;
  assign out_last  = out_last_r;

endmodule

FILE: hw/rtl/lir_chk.sv
// ----------------------------------------------------------------------------
// lir_chk: port-level checks for the linear interpolation resampler
// Watches the handshakes and the idle/busy relation seen at the ports.
// ----------------------------------------------------------------------------
module lir_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_left,
  input logic [15:0] out_right,
  input logic        out_last,
  input logic        psel,
  input logic        penable,
  input logic        pwrite
);

  // A pending result means the block is busy with its item
  a_ready_vs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("in_ready high while a result is pending");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) &&
    $stable(out_right) && $stable(out_last))
    else $error("stalled result changed");

  // Results are spaced: a taken result is not followed at once by another
  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("result offered right after a take");

  // A register write on an idle block keeps it idle
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && in_ready && !in_valid |=> in_ready)
    else $error("register write left the block busy");

endmodule

bind linear_interp_resampler lir_chk u_lir_chk (.*);
